// ===== src/gpll_pkg.sv =====
// Shared types, constants and sine lookup for the grid phase-locked loop.
`timescale 1ns / 1ps
`default_nettype none

package gpll_pkg;

  // Angle and amplitude of the per-degree sine table.
  localparam int unsigned ANGLE_STEPS    = 360;
  localparam int unsigned SINE_AMPLITUDE = 4096;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_NOMINAL_STEP = 2'd0;
  localparam logic [1:0] REG_LOCK_TARGET  = 2'd1;

  // Register reset values.
  localparam logic [13:0] NOMINAL_STEP_RESET = 14'd2534;
  localparam logic [14:0] LOCK_TARGET_RESET  = 15'd1500;

  // Loop constants.
  localparam logic signed [16:0] ERR_CLAMP      = 17'sd500;
  localparam logic signed [16:0] ERR_LOCK_LIMIT = 17'sd174;
  localparam logic signed [16:0] INPH_LOCK_MIN  = 17'sd512;
  localparam logic signed [14:0] KP_GAIN        = 15'sd11000;
  localparam logic signed [14:0] KI_GAIN        = 15'sd1408;
  localparam logic signed [13:0] PI_LIMIT       = 14'sd1267;
  localparam logic signed [31:0] INTEG_LIMIT    = 32'sh4F30000;
  localparam logic signed [25:0] FULL_TURN      = 26'sd23592960;

  typedef logic [8:0]         deg_t;
  typedef logic signed [13:0] sample_t;

  // One request to the shared multiply-accumulate unit.
  typedef struct packed {
    logic signed [15:0] op_a;
    logic signed [14:0] op_b;
    logic signed [31:0] addend;
    logic               subtract;
  } mac_req_t;

  // Quarter wave of round(4096 * sin(deg)), 0 to 90 degrees.
  localparam logic [12:0] QUARTER_SINE [91] = '{
    13'd0,    13'd71,   13'd143,  13'd214,  13'd286,  13'd357,  13'd428,  13'd499,
    13'd570,  13'd641,  13'd711,  13'd782,  13'd852,  13'd921,  13'd991,  13'd1060,
    13'd1129, 13'd1198, 13'd1266, 13'd1334, 13'd1401, 13'd1468, 13'd1534, 13'd1600,
    13'd1666, 13'd1731, 13'd1796, 13'd1860, 13'd1923, 13'd1986, 13'd2048, 13'd2110,
    13'd2171, 13'd2231, 13'd2290, 13'd2349, 13'd2408, 13'd2465, 13'd2522, 13'd2578,
    13'd2633, 13'd2687, 13'd2741, 13'd2793, 13'd2845, 13'd2896, 13'd2946, 13'd2996,
    13'd3044, 13'd3091, 13'd3138, 13'd3183, 13'd3228, 13'd3271, 13'd3314, 13'd3355,
    13'd3396, 13'd3435, 13'd3474, 13'd3511, 13'd3547, 13'd3582, 13'd3617, 13'd3650,
    13'd3681, 13'd3712, 13'd3742, 13'd3770, 13'd3798, 13'd3824, 13'd3849, 13'd3873,
    13'd3896, 13'd3917, 13'd3937, 13'd3956, 13'd3974, 13'd3991, 13'd4006, 13'd4021,
    13'd4034, 13'd4046, 13'd4056, 13'd4065, 13'd4074, 13'd4080, 13'd4086, 13'd4090,
    13'd4094, 13'd4095, 13'd4096
  };

  // Full-wave sine of an integer degree in 0..359, unfolded from the quarter wave.
  function automatic sample_t sine_lookup(input deg_t deg);
    logic [8:0]  fold;
    logic [6:0]  idx;
    logic        neg;
    logic [31:0] mag;
    sample_t     res;
    fold = 9'd0;
    neg  = 1'b0;
    if (deg <= 9'd90) begin
      fold = deg;
    end else if (deg <= 9'd180) begin
      fold = 9'd180 - deg;
    end else if (deg <= 9'd270) begin
      fold = deg - 9'd180;
      neg  = 1'b1;
    end else begin
      fold = 9'd360 - deg;
      neg  = 1'b1;
    end
    idx = fold[6:0];
    mag = ({19'd0, QUARTER_SINE[idx]} * SINE_AMPLITUDE + 32'd2048) >> 12;
    res = mag[13:0];
    if (neg) begin
      res = -res;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/grid_phase_locked_loop.sv =====
// Top level of the synchronous reference frame phase-locked loop.
//
// Each input beat carries the reference sine and cosine (Q12) and a tracking enable. With
// tracking on, the block forms the phase error and in-phase terms against its own sine and
// cosine, runs a clamped PI loop, advances a 360-degree angle accumulator, looks up the new
// sine and cosine and updates the lock counter and flags; with tracking off it clears the
// angle, integrator, lock counter and main lock flag. One result beat follows each input
// beat. A tracking beat runs the six products one after another on the single shared
// multiply-accumulate unit, then the angle step and the table lookup; a non-tracking beat
// goes straight to the output stage. The block takes no new beat until the result has been
// placed in the output register, which waits while an earlier result still stalls there.
// Input is accepted again while a finished result still waits on the output register.
// Configuration writes take effect at once and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module grid_phase_locked_loop (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               tracking_enable_i,
  input  logic signed [15:0] ref_sin_i,
  input  logic signed [15:0] ref_cos_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [13:0] sin_out_o,
  output logic signed [13:0] cos_out_o,
  output logic [8:0]         angle_deg_o,
  output logic               locked_o,
  output logic               bypass_locked_o
);
  import gpll_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MUL_A  = 10'b0000000010,
    ST_MUL_B  = 10'b0000000100,
    ST_MUL_C  = 10'b0000001000,
    ST_MUL_D  = 10'b0000010000,
    ST_MUL_P  = 10'b0000100000,
    ST_MUL_I  = 10'b0001000000,
    ST_STEP   = 10'b0010000000,
    ST_LOOK   = 10'b0100000000,
    ST_FINISH = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [13:0] nominal_q, nominal_d;
  logic [14:0] target_q, target_d;

  // Loop state.
  logic [24:0]        angle_q, angle_d;
  logic signed [27:0] integ_q, integ_d;
  logic [14:0]        cnt_q, cnt_d;
  sample_t            own_sin_q, own_sin_d;
  sample_t            own_cos_q, own_cos_d;
  logic               lock_q, lock_d;
  logic               bypass_q, bypass_d;

  // Working registers of one beat.
  logic signed [15:0] rs_q, rs_d;
  logic signed [15:0] rc_q, rc_d;
  logic signed [31:0] acc_q, acc_d;
  logic signed [16:0] err_q, err_d;
  logic signed [16:0] inph_q, inph_d;
  logic signed [9:0]  e_q, e_d;
  logic signed [12:0] prop_q, prop_d;
  logic signed [11:0] pic_q, pic_d;

  // Output register.
  logic    out_valid_q, out_valid_d;
  sample_t out_sin_q, out_sin_d;
  sample_t out_cos_q, out_cos_d;
  deg_t    out_deg_q, out_deg_d;
  logic    out_lock_q, out_lock_d;
  logic    out_bypass_q, out_bypass_d;

  mac_req_t           mac_req;
  logic signed [31:0] mac_res;
  sample_t            look_sin;
  sample_t            look_cos;

  logic signed [13:0] pi_sum;
  logic signed [15:0] step;
  logic signed [21:0] delta;
  logic signed [25:0] angle_sum;
  logic               bad_tick;
  logic [15:0]        cnt_inc;
  logic               out_free;

  gpll_mac u_mac (
    .req_i    (mac_req),
    .result_o (mac_res)
  );

  gpll_sine u_sine (
    .deg_i (angle_q[24:16]),
    .sin_o (look_sin),
    .cos_o (look_cos)
  );

  // Datapath terms that feed the sequencer.
  assign pi_sum    = {{2{integ_q[27]}}, integ_q[27:16]} + {prop_q[12], prop_q};
  assign step      = $signed({2'b00, nominal_q}) + {{4{pic_q[11]}}, pic_q};
  assign delta     = {step, 6'b000000};
  assign angle_sum = $signed({1'b0, angle_q}) + {{4{delta[21]}}, delta};
  assign bad_tick  = (inph_q < INPH_LOCK_MIN) || (err_q > ERR_LOCK_LIMIT) ||
                     (err_q < -ERR_LOCK_LIMIT);
  assign cnt_inc   = {1'b0, cnt_q} + 16'd1;
  assign out_free  = !out_valid_q || out_ready_i;

  // Sequencer: one product on the shared unit per state, then step, lookup and output.
  always_comb begin
    state_d      = state_q;
    nominal_d    = nominal_q;
    target_d     = target_q;
    angle_d      = angle_q;
    integ_d      = integ_q;
    cnt_d        = cnt_q;
    own_sin_d    = own_sin_q;
    own_cos_d    = own_cos_q;
    lock_d       = lock_q;
    bypass_d     = bypass_q;
    rs_d         = rs_q;
    rc_d         = rc_q;
    acc_d        = acc_q;
    err_d        = err_q;
    inph_d       = inph_q;
    e_d          = e_q;
    prop_d       = prop_q;
    pic_d        = pic_q;
    out_sin_d    = out_sin_q;
    out_cos_d    = out_cos_q;
    out_deg_d    = out_deg_q;
    out_lock_d   = out_lock_q;
    out_bypass_d = out_bypass_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    mac_req      = '0;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NOMINAL_STEP: nominal_d = cfg_wdata_i[13:0];
        REG_LOCK_TARGET:  target_d  = cfg_wdata_i;
        default: begin
        end
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rs_d = ref_sin_i;
          rc_d = ref_cos_i;
          if (tracking_enable_i) begin
            state_d = ST_MUL_A;
          end else begin
            angle_d = '0;
            integ_d = '0;
            cnt_d   = '0;
            lock_d  = 1'b0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_MUL_A: begin
        mac_req.op_a = rs_q;
        mac_req.op_b = {own_cos_q[13], own_cos_q};
        acc_d        = mac_res;
        state_d      = ST_MUL_B;
      end
      ST_MUL_B: begin
        // Phase error: ref_sin * own_cos - ref_cos * own_sin.
        mac_req.op_a     = rc_q;
        mac_req.op_b     = {own_sin_q[13], own_sin_q};
        mac_req.addend   = acc_q;
        mac_req.subtract = 1'b1;
        err_d            = mac_res[30:14];
        state_d          = ST_MUL_C;
      end
      ST_MUL_C: begin
        mac_req.op_a = rc_q;
        mac_req.op_b = {own_cos_q[13], own_cos_q};
        acc_d        = mac_res;
        if (err_q > ERR_CLAMP) begin
          e_d = ERR_CLAMP[9:0];
        end else if (err_q < -ERR_CLAMP) begin
          e_d = 10'(-ERR_CLAMP);
        end else begin
          e_d = err_q[9:0];
        end
        state_d = ST_MUL_D;
      end
      ST_MUL_D: begin
        // In-phase term: ref_cos * own_cos + ref_sin * own_sin.
        mac_req.op_a   = rs_q;
        mac_req.op_b   = {own_sin_q[13], own_sin_q};
        mac_req.addend = acc_q;
        inph_d         = mac_res[30:14];
        state_d        = ST_MUL_P;
      end
      ST_MUL_P: begin
        // Proportional term.
        mac_req.op_a = {{6{e_q[9]}}, e_q};
        mac_req.op_b = KP_GAIN;
        prop_d       = mac_res[24:12];
        state_d      = ST_MUL_I;
      end
      ST_MUL_I: begin
        // PI output from the old integrator, then integrator update.
        if (pi_sum > PI_LIMIT) begin
          pic_d = PI_LIMIT[11:0];
        end else if (pi_sum < -PI_LIMIT) begin
          pic_d = 12'(-PI_LIMIT);
        end else begin
          pic_d = pi_sum[11:0];
        end
        mac_req.op_a   = {{6{e_q[9]}}, e_q};
        mac_req.op_b   = KI_GAIN;
        mac_req.addend = {{4{integ_q[27]}}, integ_q};
        if (mac_res > INTEG_LIMIT) begin
          integ_d = INTEG_LIMIT[27:0];
        end else if (mac_res < -INTEG_LIMIT) begin
          integ_d = 28'(-INTEG_LIMIT);
        end else begin
          integ_d = mac_res[27:0];
        end
        state_d = ST_STEP;
      end
      ST_STEP: begin
        // Advance the angle and wrap into one turn.
        if (angle_sum >= FULL_TURN) begin
          angle_d = 25'(angle_sum - FULL_TURN);
        end else if (angle_sum < 26'sd0) begin
          angle_d = 25'(angle_sum + FULL_TURN);
        end else begin
          angle_d = angle_sum[24:0];
        end
        state_d = ST_LOOK;
      end
      ST_LOOK: begin
        own_sin_d = look_sin;
        own_cos_d = look_cos;
        // Lock counter saturates at zero and at the target.
        if (bad_tick) begin
          if (cnt_q <= 15'd1) begin
            cnt_d    = '0;
            lock_d   = 1'b0;
            bypass_d = 1'b0;
          end else begin
            cnt_d = cnt_q - 15'd1;
          end
        end else begin
          if (cnt_inc >= {1'b0, target_q}) begin
            cnt_d    = target_q;
            lock_d   = 1'b1;
            bypass_d = 1'b1;
          end else begin
            cnt_d = cnt_inc[14:0];
          end
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sin_d    = own_sin_q;
          out_cos_d    = own_cos_q;
          out_deg_d    = angle_q[24:16];
          out_lock_d   = lock_q;
          out_bypass_d = bypass_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and loop state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      nominal_q   <= NOMINAL_STEP_RESET;
      target_q    <= LOCK_TARGET_RESET;
      angle_q     <= '0;
      integ_q     <= '0;
      cnt_q       <= '0;
      own_sin_q   <= '0;
      own_cos_q   <= '0;
      lock_q      <= 1'b0;
      bypass_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      nominal_q   <= nominal_d;
      target_q    <= target_d;
      angle_q     <= angle_d;
      integ_q     <= integ_d;
      cnt_q       <= cnt_d;
      own_sin_q   <= own_sin_d;
      own_cos_q   <= own_cos_d;
      lock_q      <= lock_d;
      bypass_q    <= bypass_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    rs_q         <= rs_d;
    rc_q         <= rc_d;
    acc_q        <= acc_d;
    err_q        <= err_d;
    inph_q       <= inph_d;
    e_q          <= e_d;
    prop_q       <= prop_d;
    pic_q        <= pic_d;
    out_sin_q    <= out_sin_d;
    out_cos_q    <= out_cos_d;
    out_deg_q    <= out_deg_d;
    out_lock_q   <= out_lock_d;
    out_bypass_q <= out_bypass_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign sin_out_o       = out_sin_q;
  assign cos_out_o       = out_cos_q;
  assign angle_deg_o     = out_deg_q;
  assign locked_o        = out_lock_q;
  assign bypass_locked_o = out_bypass_q;

endmodule

`default_nettype wire

// ===== src/gpll_mac.sv =====
// Shared signed multiply-accumulate unit used for every product of the loop.
`timescale 1ns / 1ps
`default_nettype none

module gpll_mac (
  input  gpll_pkg::mac_req_t  req_i,
  output logic signed [31:0]  result_o
);
  import gpll_pkg::*;

  logic signed [30:0] prod;
  logic signed [31:0] prod_ext;

  // 16 x 15 bit signed product, then add to or subtract from the addend.
  assign prod     = $signed(req_i.op_a) * $signed(req_i.op_b);
  assign prod_ext = {prod[30], prod};
  assign result_o = req_i.subtract ? ($signed(req_i.addend) - prod_ext)
                                   : ($signed(req_i.addend) + prod_ext);

endmodule

`default_nettype wire

// ===== src/gpll_sine.sv =====
// Sine table lookup giving sine and cosine of the tracked integer degree.
`timescale 1ns / 1ps
`default_nettype none

module gpll_sine (
  input  gpll_pkg::deg_t    deg_i,
  output gpll_pkg::sample_t sin_o,
  output gpll_pkg::sample_t cos_o
);
  import gpll_pkg::*;

  logic [9:0] cos_sum;
  deg_t       cos_deg;

  // Cosine reads the table a quarter turn ahead, wrapped into one turn.
  assign cos_sum = {1'b0, deg_i} + 10'd90;
  assign cos_deg = (cos_sum >= 10'(ANGLE_STEPS)) ? 9'(cos_sum - 10'(ANGLE_STEPS))
                                                  : cos_sum[8:0];

  assign sin_o = sine_lookup(deg_i);
  assign cos_o = sine_lookup(cos_deg);

endmodule

`default_nettype wire

// ===== src/gpll_checker.sv =====
// Port-level checker for the grid phase-locked loop and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module gpll_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [13:0] sin_out_o,
  input logic signed [13:0] cos_out_o,
  input logic [8:0]         angle_deg_o,
  input logic               locked_o,
  input logic               bypass_locked_o
);

  // The block works on one beat at a time, so it is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again in the cycle after a beat was accepted");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sin_out_o) &&
      $stable(cos_out_o) && $stable(angle_deg_o) && $stable(locked_o) &&
      $stable(bypass_locked_o))
    else $error("stalled result changed");

  // The tracked angle stays within one turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> angle_deg_o <= 9'd359)
    else $error("angle out of range");

  // The main lock flag is only ever set together with the secondary flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && locked_o |-> bypass_locked_o)
    else $error("main lock set without secondary lock");

  // Sine and cosine stay within the table amplitude.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sin_out_o <= 14'sd4096 && sin_out_o >= -14'sd4096 &&
      cos_out_o <= 14'sd4096 && cos_out_o >= -14'sd4096)
    else $error("sine or cosine beyond amplitude");

endmodule

bind grid_phase_locked_loop gpll_checker u_gpll_checker (.*);

`default_nettype wire

// ===== test/grid_phase_locked_loop_tb.sv =====
// Self-checking testbench for the grid phase-locked loop with a beat-accurate loop predictor.
`timescale 1ns / 1ps

module grid_phase_locked_loop_tb;
  import gpll_pkg::*;

  // The two spare register indexes must be ignored by the block.
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  localparam int RANDOM_BEATS  = 1750;
  localparam int QUIET_BEATS   = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    logic               track;
    logic signed [15:0] rs;
    logic signed [15:0] rc;
  } ref_beat_t;

  typedef struct packed {
    sample_t s;
    sample_t c;
    deg_t    deg;
    logic    lk;
    logic    blk;
  } loop_out_t;

  logic               clk_i             = 1'b0;
  logic               rst_ni            = 1'b0;
  logic               cfg_we_i          = 1'b0;
  logic [1:0]         cfg_index_i       = 2'd0;
  logic [14:0]        cfg_wdata_i       = 15'd0;
  logic               in_valid_i        = 1'b0;
  logic               in_ready_o;
  logic               tracking_enable_i = 1'b0;
  logic signed [15:0] ref_sin_i         = 16'sd0;
  logic signed [15:0] ref_cos_i         = 16'sd0;
  logic               out_valid_o;
  logic               out_ready_i       = 1'b0;
  logic signed [13:0] sin_out_o;
  logic signed [13:0] cos_out_o;
  logic [8:0]         angle_deg_o;
  logic               locked_o;
  logic               bypass_locked_o;

  // Predicted loop state and register copies.
  longint angle_acc_q = 0;
  longint integ_q     = 0;
  longint lock_cnt_q  = 0;
  longint own_sin_q   = 0;
  longint own_cos_q   = 0;
  logic   lock_q      = 1'b0;
  logic   bypass_q    = 1'b0;
  longint nom_step    = NOMINAL_STEP_RESET;
  longint lock_target = LOCK_TARGET_RESET;

  ref_beat_t ref_beats_q[$];
  loop_out_t expected_outputs[$];

  int   beats_queued  = 0;
  int   results_seen  = 0;
  int   mismatches    = 0;
  int   cycle_cnt     = 0;
  int   send_pct      = 0;
  int   recv_pct      = 0;
  int   send_hold     = 0;
  int   recv_hold     = 0;
  logic quiet         = 1'b0;
  logic in_beat_taken = 1'b0;

  grid_phase_locked_loop uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .tracking_enable_i(tracking_enable_i),
    .ref_sin_i        (ref_sin_i),
    .ref_cos_i        (ref_cos_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sin_out_o        (sin_out_o),
    .cos_out_o        (cos_out_o),
    .angle_deg_o      (angle_deg_o),
    .locked_o         (locked_o),
    .bypass_locked_o  (bypass_locked_o)
  );

  always #10 clk_i = ~clk_i;

  // Sine of any integer degree, unfolded from the quarter-wave table.
  function automatic longint deg_sine(input int d);
    int     m;
    longint mag;
    logic   neg;
    m = d % int'(ANGLE_STEPS);
    if (m < 0) m += int'(ANGLE_STEPS);
    neg = (m > 180);
    if (neg) m -= 180;
    if (m > 90) m = 180 - m;
    mag = (longint'(QUARTER_SINE[m]) * longint'(SINE_AMPLITUDE) + 2048) >>> 12;
    return neg ? -mag : mag;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // One loop update per accepted beat; returns the result the block should show.
  task automatic advance_loop(input ref_beat_t b, output loop_out_t r);
    longint rs, rc, err, inph, e, pi_out;
    int     deg;
    if (!b.track) begin
      angle_acc_q = 0;
      integ_q     = 0;
      lock_cnt_q  = 0;
      lock_q      = 1'b0;
    end else begin
      rs     = longint'($signed(b.rs));
      rc     = longint'($signed(b.rc));
      err    = (rs * own_cos_q - rc * own_sin_q) >>> 14;
      inph   = (rc * own_cos_q + rs * own_sin_q) >>> 14;
      e      = clip(err, ERR_CLAMP);
      pi_out = clip((integ_q >>> 16) + ((e * KP_GAIN) >>> 12), PI_LIMIT);
      integ_q = clip(integ_q + e * KI_GAIN, INTEG_LIMIT);

      // The phase accumulator wraps in both directions.
      angle_acc_q += (nom_step + pi_out) * 64;
      if (angle_acc_q >= FULL_TURN) angle_acc_q -= FULL_TURN;
      else if (angle_acc_q < 0) angle_acc_q += FULL_TURN;

      deg       = int'(angle_acc_q >>> 16);
      own_sin_q = deg_sine(deg);
      own_cos_q = deg_sine(deg + 90);

      // The lock counter saturates at zero and at the target.
      if (inph < INPH_LOCK_MIN || err > ERR_LOCK_LIMIT || err < -ERR_LOCK_LIMIT) begin
        lock_cnt_q--;
        if (lock_cnt_q <= 0) begin
          lock_cnt_q = 0;
          lock_q     = 1'b0;
          bypass_q   = 1'b0;
        end
      end else begin
        lock_cnt_q++;
        if (lock_cnt_q >= lock_target) begin
          lock_cnt_q = lock_target;
          lock_q     = 1'b1;
          bypass_q   = 1'b1;
        end
      end
    end
    r.s   = sample_t'(own_sin_q);
    r.c   = sample_t'(own_cos_q);
    r.deg = deg_t'(angle_acc_q >>> 16);
    r.lk  = lock_q;
    r.blk = bypass_q;
  endtask

  task automatic note_mismatch(input string field, input int got, input int want);
    if (mismatches < MAX_PRINTED)
      $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic queue_beat(input logic track, input logic signed [15:0] rs,
                            input logic signed [15:0] rc);
    ref_beat_t b;
    b.track = track;
    b.rs    = rs;
    b.rc    = rc;
    ref_beats_q.push_back(b);
    beats_queued++;
  endtask

  // Wait until every queued beat has gone in and every result has come out.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (ref_beats_q.size() != 0 || in_valid_i || expected_outputs.size() != 0);
  endtask

  task automatic send_one(input logic track, input logic signed [15:0] rs,
                          input logic signed [15:0] rc);
    queue_beat(track, rs, rc);
    wait_drained();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_NOMINAL_STEP: nom_step = val[13:0];
      REG_LOCK_TARGET:  lock_target = val;
      default: ;
    endcase
  endtask

  // A loop restart followed by a rotating reference with noise, phase jumps, sags and dropouts.
  task automatic queue_tracking_run(input int len, input int freq_off, input int amp8,
                                    input int jit);
    longint ph, s, c, jump;
    int     deg, nz, i, a;
    logic   tr;
    queue_beat(1'b0, 16'($urandom), 16'($urandom));
    ph = 0;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 2) begin
        jump = $urandom_range(23592959);
        ph   = (ph + jump) % FULL_TURN;
      end
      a   = ($urandom_range(99) < 3) ? 1 : amp8;
      tr  = ($urandom_range(99) != 0);
      deg = int'(ph >>> 16);
      nz  = $urandom_range(2 * jit);
      nz -= jit;
      s   = deg_sine(deg) * a / 8 + nz;
      nz  = $urandom_range(2 * jit);
      nz -= jit;
      c   = deg_sine(deg + 90) * a / 8 + nz;
      queue_beat(tr, sat16(s), sat16(c));
      ph += (nom_step + freq_off) * 64;
      if (ph >= FULL_TURN) ph -= FULL_TURN;
      else if (ph < 0) ph += FULL_TURN;
    end
  endtask

  task automatic queue_noise(input int n);
    int i;
    for (i = 0; i < n; i++) queue_beat(1'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Input driver: presents queued beats and holds each until it is taken.
  always @(negedge clk_i) begin : drive_beats
    ref_beat_t nxt;
    if (!in_valid_i || in_beat_taken) begin
      if (send_hold > 0) begin
        send_hold  <= send_hold - 1;
        in_valid_i <= 1'b0;
      end else if (ref_beats_q.size() != 0 && !quiet && $urandom_range(99) < send_pct) begin
        send_hold  <= $urandom_range(8);
        in_valid_i <= 1'b0;
      end else if (ref_beats_q.size() != 0) begin
        nxt = ref_beats_q.pop_front();
        tracking_enable_i <= nxt.track;
        ref_sin_i         <= nxt.rs;
        ref_cos_i         <= nxt.rc;
        in_valid_i        <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_beat_taken = 1'b0;
  end

  // Output side: ready drops in random bursts.
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold   <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(99) < recv_pct) begin
      recv_hold   <= $urandom_range(8);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predicts on each accepted input beat and checks each accepted result beat.
  always @(posedge clk_i) begin : watch_ports
    ref_beat_t got_in;
    loop_out_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      got_in.track = tracking_enable_i;
      got_in.rs    = ref_sin_i;
      got_in.rc    = ref_cos_i;
      advance_loop(got_in, want);
      expected_outputs.push_back(want);
      in_beat_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_outputs.size() == 0) begin
        note_mismatch("unexpected result", 0, 0);
      end else begin
        want = expected_outputs.pop_front();
        if (sin_out_o !== want.s) note_mismatch("sin_out", sin_out_o, $signed(want.s));
        if (cos_out_o !== want.c) note_mismatch("cos_out", cos_out_o, $signed(want.c));
        if (angle_deg_o !== want.deg) note_mismatch("angle_deg", angle_deg_o, want.deg);
        if (locked_o !== want.lk) note_mismatch("locked", locked_o, want.lk);
        if (bypass_locked_o !== want.blk)
          note_mismatch("bypass_locked", bypass_locked_o, want.blk);
      end
      results_seen++;
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int          seg, nseg, kind, off, p;
    logic [14:0] nom_val, tgt_val;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats under the reset register values: zero and full-scale references.
    send_pct = 30;
    recv_pct = 30;
    send_one(1'b1, 16'sd0, 16'sd0);
    send_one(1'b1, 16'sh7FFF, 16'sh8000);
    send_one(1'b1, 16'sh8000, 16'sh7FFF);
    send_one(1'b1, 16'sh8000, 16'sh8000);
    send_one(1'b1, 16'sh7FFF, 16'sh7FFF);
    send_one(1'b0, -16'sd1, -16'sd1);
    send_one(1'b1, 16'sh5555, 16'shAAAA);
    send_one(1'b1, sat16(own_sin_q * 4), sat16(own_cos_q * 4));

    // Zero step and zero lock target: a negative step wraps the angle downward,
    // and the first good tick sets both lock flags.
    write_reg(REG_NOMINAL_STEP, 15'd0);
    write_reg(REG_LOCK_TARGET, 15'd0);
    send_one(1'b0, 16'sd0, 16'sd0);
    send_one(1'b1, 16'sh8000, 16'sd0);
    send_one(1'b1, sat16(own_sin_q * 4), sat16(own_cos_q * 4));
    send_one(1'b1, sat16(own_sin_q * 4), sat16(own_cos_q * 4));
    // Disabling clears the main flag but leaves the bypass flag and the sine outputs.
    send_one(1'b0, 16'sh7FFF, 16'sh8000);
    send_one(1'b1, 16'sd0, 16'sd0);
    send_one(1'b1, -16'sd1, -16'sd1);

    // Random phases, each starting from an idle block with fresh register values.
    // The run always ends with at least one phase that has no idle cycles.
    beats_queued = 0;
    p = 0;
    while (beats_queued < RANDOM_BEATS || !quiet) begin
      wait_drained();
      if (p == 0) begin
        nom_val = 15'h7FFF;
        tgt_val = 15'h7FFF;
      end else if (p == 1) begin
        nom_val = 15'd0;
        tgt_val = 15'd1;
      end else begin
        if ($urandom_range(2) == 0) begin
          nom_val = 15'($urandom);
        end else begin
          off     = $urandom_range(400);
          nom_val = 15'(int'(NOMINAL_STEP_RESET) + off - 200);
        end
        tgt_val = ($urandom_range(5) == 0) ? 15'($urandom) : 15'($urandom_range(40));
      end
      if ($urandom_range(2) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, 15'($urandom));
      if ($urandom_range(1)) begin
        write_reg(REG_NOMINAL_STEP, nom_val);
        write_reg(REG_LOCK_TARGET, tgt_val);
      end else begin
        write_reg(REG_LOCK_TARGET, tgt_val);
        write_reg(REG_NOMINAL_STEP, nom_val);
      end

      quiet = (beats_queued >= RANDOM_BEATS - QUIET_BEATS);
      case ($urandom_range(2))
        0: send_pct = 0;
        1: send_pct = 15;
        default: send_pct = 45;
      endcase
      case ($urandom_range(2))
        0: recv_pct = 0;
        1: recv_pct = 15;
        default: recv_pct = 45;
      endcase

      // Mostly tracking runs near the nominal step, some far off it, a little noise.
      nseg = $urandom_range(1, 4);
      for (seg = 0; seg < nseg; seg++) begin
        kind = $urandom_range(9);
        if (kind < 7) begin
          off = $urandom_range(60);
          off -= 30;
          queue_tracking_run($urandom_range(10, 90), off, $urandom_range(4, 20),
                             $urandom_range(40));
        end else if (kind < 9) begin
          off = $urandom_range(3000);
          off -= 1500;
          queue_tracking_run($urandom_range(10, 60), off, $urandom_range(4, 24),
                             $urandom_range(200));
        end else begin
          queue_noise($urandom_range(1, 8));
        end
      end
      p++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
